// ===== design/adddate_pkg.sv =====
// adddate_pkg: shared types, constants and calendar helpers for the
// add-days-to-date block; no dependencies
package adddate_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned COUNT_W = 15;
  localparam int unsigned CYCLE_W = 9;   // year position within the 400-year cycle

  localparam logic [YEAR_W-1:0]  YEAR_MAX    = YEAR_W'(9999);
  localparam logic [YEAR_W-1:0]  LEAP_CYCLE  = YEAR_W'(400);
  localparam logic [CYCLE_W-1:0] CYCLE_LAST  = CYCLE_W'(399);
  localparam logic [MONTH_W-1:0] MONTH_JAN   = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB   = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_DEC   = MONTH_W'(12);
  localparam logic [DAY_W-1:0]   DAY_FIRST   = DAY_W'(1);
  localparam logic [DAY_W-1:0]   DAY_DEC_END = DAY_W'(31);

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_INVALID  = 2'd1,
    STAT_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MOD  = 4'b0010,
    S_WALK = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  // leap test from the year's position in the 400-year cycle
  function automatic logic is_leap(input logic [CYCLE_W-1:0] pos);
    logic century;
    century = (pos == CYCLE_W'(100)) || (pos == CYCLE_W'(200)) || (pos == CYCLE_W'(300));
    return (pos[1:0] == 2'b00) && !century;
  endfunction

  // month length, zero for a month code that means nothing
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                    len = DAY_W'(30);
      4'd2:                                       len = leap ? DAY_W'(29) : DAY_W'(28);
      default:                                    len = '0;
    endcase
    return len;
  endfunction

endpackage

// ===== design/add_days_to_date_core.sv =====
// add_days_to_date_core: adds a day count to a Gregorian date, month by month
// depends on adddate_pkg
//
// usage:
//   input channel in_*: one transaction carries a start date (year, month,
//   day) and a day count. in_stall is high while a date is being worked on,
//   so only one transaction is in the block at a time.
//   output channel out_*: one transaction per input, with the new date and a
//   status (0 ok, 1 invalid start date echoed back, 2 past 9999-12-31,
//   date saturated). The result holds steady while out_stall is high and
//   the block takes no new input until it has been taken.
// sequence: after the accept, the year is reduced by repeated subtraction of 400
//   (up to 40 steps, at most 24 for a valid year) and the date is checked,
//   then the shared subtract/compare unit steps month by month until the
//   count lands in the last month.
//   A new date is accepted only after the result has been taken and the
//   sequencer is back in idle.
// reset: rst_n (synchronous, active low) returns the sequencer to idle and
//   drops out_valid; no clearing pass is needed.
module add_days_to_date_core
  import adddate_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [YEAR_W-1:0]  in_start_year,
  input  logic [MONTH_W-1:0] in_start_month,
  input  logic [DAY_W-1:0]   in_start_day,
  input  logic [COUNT_W-1:0] in_days_to_add,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [YEAR_W-1:0]  out_result_year,
  output logic [MONTH_W-1:0] out_result_month,
  output logic [DAY_W-1:0]   out_result_day,
  output logic [1:0]         out_status
);

  state_t             state_r, state_nxt;
  logic [YEAR_W-1:0]  year_r, year_nxt;
  logic [MONTH_W-1:0] month_r, month_nxt;
  logic [DAY_W-1:0]   day_r, day_nxt;
  logic [COUNT_W-1:0] rem_r, rem_nxt;
  logic [YEAR_W-1:0]  ymod_r, ymod_nxt;
  status_t            status_r, status_nxt;

  logic             leap;
  logic [DAY_W-1:0] dim;
  logic [DAY_W-1:0] left;
  logic             fits;
  logic             date_ok;

  // shared month unit: length of current month and days left in it
  assign leap    = is_leap(ymod_r[CYCLE_W-1:0]);
  assign dim     = month_days(month_r, leap);
  assign left    = dim - day_r;
  assign fits    = rem_r <= {{(COUNT_W-DAY_W){1'b0}}, left};
  assign date_ok = (year_r != '0) && (year_r <= YEAR_MAX) && (dim != '0) &&
                   (day_r != '0) && (day_r <= dim);

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    year_nxt   = year_r;
    month_nxt  = month_r;
    day_nxt    = day_r;
    rem_nxt    = rem_r;
    ymod_nxt   = ymod_r;
    status_nxt = status_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          year_nxt   = in_start_year;
          month_nxt  = in_start_month;
          day_nxt    = in_start_day;
          rem_nxt    = in_days_to_add;
          ymod_nxt   = in_start_year;
          status_nxt = STAT_OK;
          state_nxt  = S_MOD;
        end
      end
      S_MOD: begin
        // reduce year into the leap cycle, then validate the start date
        if (ymod_r >= LEAP_CYCLE) begin
          ymod_nxt = ymod_r - LEAP_CYCLE;
        end else if (date_ok) begin
          state_nxt = S_WALK;
        end else begin
          status_nxt = STAT_INVALID;
          state_nxt  = S_DONE;
        end
      end
      S_WALK: begin
        if (fits) begin
          day_nxt   = day_r + rem_r[DAY_W-1:0];
          state_nxt = S_DONE;
        end else begin
          rem_nxt = rem_r - {{(COUNT_W-DAY_W){1'b0}}, left} - COUNT_W'(1);
          day_nxt = DAY_FIRST;
          if (month_r < MONTH_DEC) begin
            month_nxt = month_r + MONTH_W'(1);
          end else if (year_r >= YEAR_MAX) begin
            year_nxt   = YEAR_MAX;
            month_nxt  = MONTH_DEC;
            day_nxt    = DAY_DEC_END;
            status_nxt = STAT_OVERFLOW;
            state_nxt  = S_DONE;
          end else begin
            year_nxt  = year_r + YEAR_W'(1);
            month_nxt = MONTH_JAN;
            ymod_nxt  = (ymod_r[CYCLE_W-1:0] == CYCLE_LAST) ? '0 : ymod_r + YEAR_W'(1);
          end
        end
      end
      S_DONE: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    year_r   <= year_nxt;
    month_r  <= month_nxt;
    day_r    <= day_nxt;
    rem_r    <= rem_nxt;
    ymod_r   <= ymod_nxt;
    status_r <= status_nxt;
  end

  // ports
  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = (state_r == S_DONE);
  assign out_result_year  = year_r;
  assign out_result_month = month_r;
  assign out_result_day   = day_r;
  assign out_status       = status_r;

`ifndef SYNTH
  // an accepted date never produces a result in the very next cycle
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !out_valid)
    else $error("result presented one cycle after accept");

  // each month step strictly lowers the remaining count
  a_rem_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && state_nxt == S_WALK) |=> (rem_r < $past(rem_r)))
    else $error("remaining day count did not shrink");

  // a good result is a real calendar date
  a_result_sane: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STAT_OK) |->
      (month_r != '0 && month_r <= MONTH_DEC && day_r != '0 && day_r <= dim))
    else $error("ok result is not a valid date");

  // overflow always saturates to the last representable date
  a_overflow_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STAT_OVERFLOW) |->
      (year_r == YEAR_MAX && month_r == MONTH_DEC && day_r == DAY_DEC_END))
    else $error("overflow result not saturated");
`endif

endmodule
